>>> hw/rtl/pbmq_pkg.sv
package pbmq_pkg;

  // Default converter width
  localparam int ADC_BITS_DEF = 10;

  // Item operations
  localparam logic [1:0] OP_IR_SAMPLE   = 2'd0;
  localparam logic [1:0] OP_MOTION      = 2'd1;
  localparam logic [1:0] OP_WR_STATUS   = 2'd2;
  localparam logic [1:0] OP_LOAD_THRESH = 2'd3;

  // Event status codes
  localparam logic [2:0] ST_NONE         = 3'd0;
  localparam logic [2:0] ST_CAL_PRESSED  = 3'd1;
  localparam logic [2:0] ST_CAL_RELEASED = 3'd2;
  localparam logic [2:0] ST_SHORT        = 3'd3;
  localparam logic [2:0] ST_LONG         = 3'd4;
  localparam logic [2:0] ST_MOTION       = 3'd5;
  localparam logic [2:0] ST_FINISHED     = 3'd6;

  // Configuration register indexes
  localparam int          CFG_IDX_W           = 2;
  localparam int          CFG_DATA_W          = 16;
  localparam logic [1:0]  CFG_SHORT_PRESS_MS  = 2'd0;
  localparam logic [1:0]  CFG_LONG_PRESS_MS   = 2'd1;
  localparam logic [1:0]  CFG_CALIB_MARGIN    = 2'd2;
  localparam logic [1:0]  CFG_MOTION_OFF_DLY  = 2'd3;

  // Configuration reset values
  localparam logic [15:0] SHORT_PRESS_RST = 16'd30;
  localparam logic [15:0] LONG_PRESS_RST  = 16'd500;
  localparam logic [7:0]  CALIB_MARGIN_RST = 8'd50;
  localparam logic [7:0]  OFF_DELAY_RST   = 8'd0;

  // Seconds to milliseconds
  localparam int MS_PER_S = 1000;
  localparam int DLY_MS_W = 18;

endpackage

>>> hw/rtl/proximity_button_and_motion_qualifier_top.sv
// Each item passes the input register and then the result register before its result is valid.
// Throughput: one item per cycle unless stalled; the input register still takes one item while a result
// waits, and in_stall rises only when both registers are full and out_stall is high.
// Reset: synchronous active-low rst_n clears valids, event status, threshold, press
// and motion tracking, and loads the configuration registers with their defaults.
module proximity_button_and_motion_qualifier_top
  import pbmq_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_op,
  input  logic [31:0]           in_now_ms,
  input  logic [ADC_BITS-1:0]   in_adc_sample,
  input  logic                  in_motion_a,
  input  logic                  in_motion_b,
  input  logic [2:0]            in_new_status,
  input  logic [ADC_BITS:0]     in_threshold_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_event_status,
  output logic [ADC_BITS:0]     out_press_threshold,
  output logic [ADC_BITS-1:0]   out_held_distance,
  output logic                  out_released,
  output logic [31:0]           out_press_duration_ms
);

  localparam int THR_W = ADC_BITS + 1;
  localparam logic [THR_W-1:0] THR_MAX =
    THR_W'((2 ** ADC_BITS) - 1 + 255);

  // configuration registers
  logic [15:0] cfg_short_r;
  logic [15:0] cfg_long_r;
  logic [7:0]  cfg_margin_r;
  logic [7:0]  cfg_off_dly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_short_r   <= SHORT_PRESS_RST;
      cfg_long_r    <= LONG_PRESS_RST;
      cfg_margin_r  <= CALIB_MARGIN_RST;
      cfg_off_dly_r <= OFF_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_PRESS_MS: cfg_short_r   <= cfg_wdata;
        CFG_LONG_PRESS_MS:  cfg_long_r    <= cfg_wdata;
        CFG_CALIB_MARGIN:   cfg_margin_r  <= cfg_wdata[7:0];
        CFG_MOTION_OFF_DLY: cfg_off_dly_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // handshake control
  logic s1_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic fire;
  logic in_xfer;

  assign out_adv  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_xfer || (s1_valid_r && !out_adv);
      out_valid_r <= fire || (out_valid_r && out_stall);
    end
  end

  // input register
  logic [1:0]          op_r;
  logic [31:0]         now_r;
  logic [ADC_BITS-1:0] sample_r;
  logic                mot_a_r;
  logic                mot_b_r;
  logic [2:0]          nst_r;
  logic [THR_W-1:0]    tv_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_op;
      now_r    <= in_now_ms;
      sample_r <= in_adc_sample;
      mot_a_r  <= in_motion_a;
      mot_b_r  <= in_motion_b;
      nst_r    <= in_new_status;
      tv_r     <= in_threshold_value;
    end
  end

  // block state
  logic [2:0]          status_r, status_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic [31:0]         press_start_r, press_start_nxt;
  logic                press_act_r, press_act_nxt;
  logic [31:0]         press_len_r, press_len_nxt;
  logic [ADC_BITS-1:0] dist_r, dist_nxt;
  logic                mot_seen_r, mot_seen_nxt;
  logic                off_run_r, off_run_nxt;
  logic [31:0]         off_start_r, off_start_nxt;
  logic                rel_nxt;
  logic [31:0]         dur_nxt;

  // datapath terms
  logic [THR_W-1:0]    cal_sum;
  logic [31:0]         start_eff;
  logic [31:0]         cur_len;
  logic [31:0]         off_elapsed;
  logic [DLY_MS_W-1:0] off_dly_ms;

  assign cal_sum     = THR_W'(sample_r) + THR_W'(cfg_margin_r);
  assign start_eff   = press_act_r ? press_start_r : now_r;
  assign cur_len     = now_r - start_eff;
  assign off_elapsed = now_r - off_start_r;
  assign off_dly_ms  = DLY_MS_W'(cfg_off_dly_r) * DLY_MS_W'(MS_PER_S);

  // per-item update
  always_comb begin
    status_nxt      = status_r;
    thr_nxt         = thr_r;
    press_start_nxt = press_start_r;
    press_act_nxt   = press_act_r;
    press_len_nxt   = press_len_r;
    dist_nxt        = dist_r;
    mot_seen_nxt    = mot_seen_r;
    off_run_nxt     = off_run_r;
    off_start_nxt   = off_start_r;
    rel_nxt         = 1'b0;
    dur_nxt         = '0;
    case (op_r)
      OP_IR_SAMPLE: begin
        if (status_r == ST_CAL_PRESSED) begin
          // calibration: track max of sample plus margin
          if (cal_sum > thr_r) thr_nxt = cal_sum;
        end else if (THR_W'(sample_r) >= thr_r) begin
          press_act_nxt   = 1'b1;
          press_start_nxt = start_eff;
          press_len_nxt   = cur_len;
          if (cur_len > 32'(cfg_long_r) || status_r == ST_LONG) begin
            status_nxt = ST_LONG;
            dist_nxt   = sample_r;
          end
        end else if (press_act_r) begin
          // release
          if (press_len_r > 32'(cfg_short_r) && press_len_r < 32'(cfg_long_r) &&
              status_r != ST_LONG) begin
            status_nxt = ST_SHORT;
          end else begin
            status_nxt = ST_NONE;
          end
          rel_nxt         = 1'b1;
          dur_nxt         = press_len_r;
          press_len_nxt   = '0;
          press_start_nxt = '0;
          press_act_nxt   = 1'b0;
        end
      end
      OP_MOTION: begin
        if (status_r == ST_NONE) begin
          if (mot_a_r || mot_b_r) begin
            mot_seen_nxt = 1'b1;
            off_run_nxt  = 1'b0;
            status_nxt   = ST_MOTION;
          end else if (mot_seen_r && !off_run_r) begin
            mot_seen_nxt  = 1'b0;
            off_run_nxt   = 1'b1;
            off_start_nxt = now_r;
          end else if (off_run_r && off_elapsed >= 32'(off_dly_ms)) begin
            off_run_nxt = 1'b0;
            status_nxt  = ST_FINISHED;
          end
        end
      end
      OP_WR_STATUS: begin
        // a write of the unused code is dropped
        if (nst_r <= ST_FINISHED) begin
          status_nxt = nst_r;
          if (nst_r == ST_CAL_PRESSED) thr_nxt = '0;
        end
      end
      OP_LOAD_THRESH: begin
        thr_nxt = (tv_r > THR_MAX) ? THR_MAX : tv_r;
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r      <= ST_NONE;
      thr_r         <= '0;
      press_start_r <= '0;
      press_act_r   <= 1'b0;
      press_len_r   <= '0;
      dist_r        <= '0;
      mot_seen_r    <= 1'b0;
      off_run_r     <= 1'b0;
      off_start_r   <= '0;
    end else if (fire) begin
      status_r      <= status_nxt;
      thr_r         <= thr_nxt;
      press_start_r <= press_start_nxt;
      press_act_r   <= press_act_nxt;
      press_len_r   <= press_len_nxt;
      dist_r        <= dist_nxt;
      mot_seen_r    <= mot_seen_nxt;
      off_run_r     <= off_run_nxt;
      off_start_r   <= off_start_nxt;
    end
  end

  // result register
  logic [2:0]          res_status_r;
  logic [THR_W-1:0]    res_thr_r;
  logic [ADC_BITS-1:0] res_dist_r;
  logic                res_rel_r;
  logic [31:0]         res_dur_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      res_status_r <= status_nxt;
      res_thr_r    <= thr_nxt;
      res_dist_r   <= dist_nxt;
      res_rel_r    <= rel_nxt;
      res_dur_r    <= dur_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_event_status      = res_status_r;
  assign out_press_threshold   = res_thr_r;
  assign out_held_distance     = res_dist_r;
  assign out_released          = res_rel_r;
  assign out_press_duration_ms = res_dur_r;

endmodule

>>> hw/rtl/pbmq_checker.sv
module pbmq_checker
  import pbmq_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [2:0]            out_event_status,
  input logic [ADC_BITS:0]     out_press_threshold,
  input logic [ADC_BITS-1:0]   out_held_distance,
  input logic                  out_released,
  input logic [31:0]           out_press_duration_ms
);

  localparam logic [ADC_BITS:0] THR_MAX = (ADC_BITS + 1)'((2 ** ADC_BITS) - 1 + 255);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // duration is reported only on a release
  a_dur_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_released |-> out_press_duration_ms == 32'd0)
    else $error("nonzero duration without release");

  // a release leaves either short press or none
  a_rel_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_released |-> (out_event_status == ST_SHORT ||
                                   out_event_status == ST_NONE))
    else $error("release with wrong status");

  // threshold never passes its saturation value
  a_thr_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_press_threshold <= THR_MAX)
    else $error("threshold above maximum");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_status) &&
      $stable(out_press_threshold) && $stable(out_held_distance) &&
      $stable(out_released) && $stable(out_press_duration_ms))
    else $error("stalled result changed");

endmodule

bind proximity_button_and_motion_qualifier_top pbmq_checker #(.ADC_BITS(ADC_BITS)) u_pbmq_checker (.*);
